// ===== design/plle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plle_pkg
// Operation and status codes of the pooled linked list engine.
// ----------------------------------------------------------------------------
package plle_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POOL_FULL = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage
`default_nettype wire

// ===== design/pooled_linked_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pooled_linked_list_engine
// Singly linked list of letters in a fixed slot pool with a free list.
//
// Request channel (req_valid / req_stall): opcode, position, letter. A word is
// taken when req_valid is high and req_stall is low. Insert links a free slot
// before the 1-based position (zero or past the end appends), delete unlinks
// the node at a position and frees its slot, read returns its letter.
// Response channel (rsp_valid / rsp_stall): status, slot, read_letter, length,
// one word per request, held in an output register until taken.
// The walk follows one link per cycle through the link memory read port,
// stopping at the position or at the list end. Early exits (pool full,
// empty list, no operation) go straight to the response. One request is
// worked at a time: req_stall is high from acceptance until the response
// is loaded.
// Reset: synchronous, active high. After reset the free chain is written into
// the link memory, one slot a cycle, with req_stall high.
// A stalled response holds its word; the next request may still be accepted
// and worked, and its response waits until the output register frees.
// ----------------------------------------------------------------------------
module pooled_linked_list_engine #(
  parameter int LIST_SLOTS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [1:0] opcode,
  input  wire logic [6:0] position,
  input  wire logic [7:0] letter,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic [1:0]      status,
  output logic [5:0]      slot,
  output logic [7:0]      read_letter,
  output logic [6:0]      length
);

  localparam int SW = $clog2(LIST_SLOTS);
  localparam int LW = $clog2(LIST_SLOTS + 1);
  localparam int IW = $clog2(LIST_SLOTS + 2);
  localparam int PW = (IW > 7) ? IW : 7;
  localparam logic [LW-1:0] END_MARK = LW'(LIST_SLOTS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(LIST_SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE,
    S_WALK,
    S_FIX1,
    S_FIX2,
    S_DONE
  } state_t;

  function automatic logic [LW-1:0] clamp(input logic [LW-1:0] l);
    clamp = (l >= END_MARK) ? END_MARK : l;
  endfunction

  state_t          state;
  logic [SW-1:0]   clr;
  logic [LW-1:0]   head;
  logic [LW-1:0]   free_top;
  logic [LW-1:0]   count;
  plle_pkg::op_t   op_q;
  logic [6:0]      pos_q;
  logic [7:0]      let_q;
  logic [LW-1:0]   cur;
  logic [LW-1:0]   prev;
  logic [LW-1:0]   nxt_q;
  logic [LW-1:0]   new_free;
  logic [IW-1:0]   idx;
  logic [1:0]      r_status;
  logic [LW-1:0]   r_slot;
  logic [7:0]      r_letter;

  logic [LW-1:0]   link_mem [LIST_SLOTS];
  logic [7:0]      letter_mem [LIST_SLOTS];
  logic [LW-1:0]   link_q;
  logic [7:0]      letter_q;

  logic [SW-1:0]   link_raddr;
  logic            link_we;
  logic [SW-1:0]   link_waddr;
  logic [LW-1:0]   link_wdata;
  logic            letter_we;

  logic            accept;
  logic            walk_go;
  logic            at_head;
  logic [LW-1:0]   link_nxt;
  logic            out_free;
  logic [LW+5:0]   slot_ext;
  logic [LW+6:0]   len_ext;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign link_nxt  = clamp(link_q);
  assign walk_go   = (PW'(pos_q) != PW'(idx)) && (cur != END_MARK)
                     && (idx <= IW'(LIST_SLOTS));
  assign at_head   = (cur == head) || (prev == END_MARK);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign slot_ext  = (LW + 6)'(r_slot);
  assign len_ext   = (LW + 7)'(count);
  assign letter_we = (state == S_FREE);

  always_comb begin
    link_raddr = cur[SW-1:0];
    link_we    = 1'b0;
    link_waddr = clr;
    link_wdata = LW'(clr) + LW'(1);
    case (state)
      S_CLEAR: begin
        link_we = 1'b1;
      end
      S_IDLE: begin
        if (plle_pkg::op_t'(opcode) == plle_pkg::OP_INSERT) begin
          link_raddr = free_top[SW-1:0];
        end else begin
          link_raddr = head[SW-1:0];
        end
      end
      S_FREE: begin
        link_raddr = head[SW-1:0];
      end
      S_WALK: begin
        if (walk_go) begin
          link_raddr = link_nxt[SW-1:0];
        end
      end
      S_FIX1: begin
        if (op_q == plle_pkg::OP_INSERT) begin
          link_we = 1'b1;
          if (at_head) begin
            link_waddr = r_slot[SW-1:0];
            link_wdata = cur;
          end else begin
            link_waddr = prev[SW-1:0];
            link_wdata = r_slot;
          end
        end else if (op_q == plle_pkg::OP_DELETE && cur != END_MARK && !at_head) begin
          link_we    = 1'b1;
          link_waddr = prev[SW-1:0];
          link_wdata = nxt_q;
        end
      end
      S_FIX2: begin
        link_we = 1'b1;
        if (op_q == plle_pkg::OP_INSERT) begin
          link_waddr = r_slot[SW-1:0];
          link_wdata = cur;
        end else begin
          link_waddr = cur[SW-1:0];
          link_wdata = free_top;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_q <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (letter_we) begin
      letter_mem[r_slot[SW-1:0]] <= let_q;
    end
    letter_q <= letter_mem[cur[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      head      <= END_MARK;
      free_top  <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + SW'(1);
          if (clr == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q     <= plle_pkg::op_t'(opcode);
            pos_q    <= position;
            let_q    <= letter;
            cur      <= head;
            prev     <= END_MARK;
            idx      <= IW'(1);
            r_letter <= '0;
            r_slot   <= '0;
            r_status <= plle_pkg::ST_OK;
            case (plle_pkg::op_t'(opcode))
              plle_pkg::OP_INSERT: begin
                if (free_top == END_MARK) begin
                  r_status <= plle_pkg::ST_POOL_FULL;
                  state    <= S_DONE;
                end else begin
                  r_slot <= free_top;
                  state  <= S_FREE;
                end
              end
              plle_pkg::OP_DELETE, plle_pkg::OP_READ: begin
                if (head == END_MARK) begin
                  r_status <= plle_pkg::ST_EMPTY;
                  state    <= S_DONE;
                end else begin
                  state <= S_WALK;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_FREE: begin
          new_free <= link_nxt;
          state    <= S_WALK;
        end
        S_WALK: begin
          if (walk_go) begin
            prev <= cur;
            cur  <= link_nxt;
            idx  <= idx + IW'(1);
          end else begin
            nxt_q <= link_nxt;
            state <= S_FIX1;
          end
        end
        S_FIX1: begin
          case (op_q)
            plle_pkg::OP_INSERT: begin
              if (at_head) begin
                head  <= r_slot;
                state <= S_DONE;
              end else begin
                state <= S_FIX2;
              end
              free_top <= new_free;
              count    <= count + LW'(1);
            end
            plle_pkg::OP_DELETE: begin
              if (cur == END_MARK) begin
                r_status <= plle_pkg::ST_NOT_FOUND;
                state    <= S_DONE;
              end else begin
                if (at_head) begin
                  head <= nxt_q;
                end
                if (count != '0) begin
                  count <= count - LW'(1);
                end
                r_slot <= cur;
                state  <= S_FIX2;
              end
            end
            plle_pkg::OP_READ: begin
              if (cur == END_MARK) begin
                r_status <= plle_pkg::ST_NOT_FOUND;
              end else begin
                r_slot   <= cur;
                r_letter <= letter_q;
              end
              state <= S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_FIX2: begin
          if (op_q == plle_pkg::OP_DELETE) begin
            free_top <= cur;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid   <= 1'b1;
            status      <= r_status;
            slot        <= slot_ext[5:0];
            read_letter <= r_letter;
            length      <= len_ext[6:0];
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= END_MARK)
    else $error("item count exceeds pool size");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == (head == END_MARK))
    else $error("head and item count disagree on empty list");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_top <= END_MARK)
    else $error("free list top out of range");

  a_full_exit: assert property (@(posedge clk) disable iff (rst)
    accept && plle_pkg::op_t'(opcode) == plle_pkg::OP_INSERT && free_top == END_MARK
    |=> state == S_DONE && r_status == plle_pkg::ST_POOL_FULL)
    else $error("insert on full pool did not exit early");

endmodule
`default_nettype wire
